FILE: hw/rtl/wind_vector_time_average_core_macros.svh
// Assertion macros shared by the wind vector averaging RTL
`ifndef WIND_VECTOR_TIME_AVERAGE_CORE_MACROS_SVH
`define WIND_VECTOR_TIME_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WVTA_ASSERT_SAME(label, CLK, RSTN, ante, cons, msg) \
    label: assert property (@(posedge CLK) disable iff (!RSTN) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WVTA_ASSERT_NEXT(label, CLK, RSTN, ante, cons, msg) \
    label: assert property (@(posedge CLK) disable iff (!RSTN) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wvta_pkg.sv
// Shared types and constants for the wind vector time average core
package wvta_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int MIN_DUR_W  = 16;
    localparam int COUNT_W    = 16;

    localparam logic [MIN_DUR_W-1:0] MIN_DUR_RESET = 16'd100;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 16'hFFFF;

    // Register index, taken from the word address bit of paddr
    localparam logic REG_MIN_DURATION = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_COMMIT
    } wvta_state_t;

    // Sequencer strobes to the serial arithmetic units
    typedef struct packed {
        logic clear;
        logic mul;
        logic div_load;
        logic div;
    } wvta_ctl_t;

endpackage

FILE: hw/rtl/wvta_cfg.sv
// APB register file holding the minimum averaging duration
module wvta_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wvta_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wvta_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wvta_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [wvta_pkg::MIN_DUR_W-1:0]   min_duration
);
    import wvta_pkg::*;

    logic [MIN_DUR_W-1:0] min_dur_reg;
    logic                 reg_sel;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MIN_DURATION);
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dur_reg <= MIN_DUR_RESET;
        end
        else if (wr_en)
        begin
            min_dur_reg <= pwdata[MIN_DUR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = APB_DATA_W'(min_dur_reg);
        end
    end

    assign min_duration = min_dur_reg;

endmodule

FILE: hw/rtl/wvta_magsq.sv
// Bit-serial squared magnitude of a two-component vector
module wvta_magsq #(
    parameter int CW = 16
) (
    input  logic                    clk,
    input  wvta_pkg::wvta_ctl_t     ctl,
    input  logic signed [CW-1:0]    sx,
    input  logic signed [CW-1:0]    sy,
    output logic [2*CW-1:0]         mag
);
    import wvta_pkg::*;

    logic [CW-1:0]   mx_reg, my_reg, bx_reg, by_reg;
    logic [CW-1:0]   mx_next, my_next, bx_next, by_next;
    logic [2*CW-1:0] acc_reg, acc_next;
    logic [CW-1:0]   abs_x, abs_y;

    always_comb
    begin
        abs_x    = sx[CW-1] ? -sx : sx;
        abs_y    = sy[CW-1] ? -sy : sy;
        mx_next  = mx_reg;
        my_next  = my_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;
        acc_next = acc_reg;
        if (ctl.div_load)
        begin
            mx_next  = abs_x;
            my_next  = abs_y;
            bx_next  = abs_x;
            by_next  = abs_y;
            acc_next = '0;
        end
        else if (ctl.div)
        begin
            // one multiplier bit of each square per cycle, MSB first
            acc_next = {acc_reg[2*CW-2:0], 1'b0}
                     + (bx_reg[CW-1] ? (2*CW)'(mx_reg) : '0)
                     + (by_reg[CW-1] ? (2*CW)'(my_reg) : '0);
            bx_next  = {bx_reg[CW-2:0], 1'b0};
            by_next  = {by_reg[CW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        acc_reg <= acc_next;
    end

    assign mag = acc_reg;

endmodule

FILE: hw/rtl/wvta_wavg.sv
// Serial weighted sum of two components and restoring divide by the total weight
module wvta_wavg #(
    parameter int CW = 16,
    parameter int TW = 32
) (
    input  logic                    clk,
    input  wvta_pkg::wvta_ctl_t     ctl,
    input  logic signed [CW-1:0]    a,
    input  logic signed [CW-1:0]    b,
    input  logic                    w1_bit,
    input  logic                    w2_bit,
    input  logic [TW:0]             total,
    output logic signed [CW-1:0]    quot
);
    import wvta_pkg::*;

    localparam int ACC_W = CW + TW + 1;
    localparam int REM_W = TW + 1;

    logic signed [ACC_W-1:0] acc_reg, acc_next, add_a, add_b;
    logic [ACC_W-1:0]        acc_mag;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [CW-1:0]           dig_reg, dig_next;
    logic                    neg_reg, neg_next;
    logic [REM_W:0]          trial, diff;
    logic                    geq;

    always_comb
    begin
        add_a   = w1_bit ? {{(ACC_W-CW){a[CW-1]}}, a} : '0;
        add_b   = w2_bit ? {{(ACC_W-CW){b[CW-1]}}, b} : '0;
        acc_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        trial   = {rem_reg, dig_reg[CW-1]};
        diff    = trial - {1'b0, total};
        geq     = (trial >= {1'b0, total});

        acc_next = acc_reg;
        rem_next = rem_reg;
        dig_next = dig_reg;
        neg_next = neg_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.mul)
        begin
            // weights arrive MSB first: double, then add the selected components
            acc_next = (acc_reg <<< 1) + add_a + add_b;
        end

        if (ctl.div_load)
        begin
            neg_next = acc_reg[ACC_W-1];
            rem_next = acc_mag[ACC_W-1:CW];
            dig_next = acc_mag[CW-1:0];
        end
        else if (ctl.div)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            rem_next = geq ? diff[REM_W-1:0] : trial[REM_W-1:0];
            dig_next = {dig_reg[CW-2:0], geq};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dig_reg <= dig_next;
        neg_reg <= neg_next;
    end

    assign quot = neg_reg ? -dig_reg : dig_reg;

endmodule

FILE: hw/rtl/wind_vector_time_average_core.sv
// Top level of the time-weighted wind vector average with gust hold
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | to core   | in_valid / in_stall     | kind, sample_x, sample_y, time_ms
//  out     | from core | out_valid / out_stall   | avg_x/y, gust_x/y, sample_count,
//          |           |                         | interval_ms, has_value
//  apb     | to core   | psel/penable/pready     | paddr, pwdata, prdata
//
// A wind sample passes through accept, the serial multiply over the weight bits, the
// load of the restoring divider, its divide over the quotient bits, and commit. A restart
// goes from accept straight to commit.
// The result register frees the input side: a new transaction is taken while a
// result still waits, and commit holds only while the result register is full and out_stall is high.
// Reset is asynchronous and clears all averaging state; min_duration_ms resets to 100.
`include "wind_vector_time_average_core_macros.svh"

module wind_vector_time_average_core #(
    parameter int TIME_WIDTH = 32,
    parameter int COMP_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic signed [COMP_WIDTH-1:0]     sample_x,
    input  logic signed [COMP_WIDTH-1:0]     sample_y,
    input  logic [TIME_WIDTH-1:0]            time_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [COMP_WIDTH-1:0]     avg_x,
    output logic signed [COMP_WIDTH-1:0]     avg_y,
    output logic signed [COMP_WIDTH-1:0]     gust_x,
    output logic signed [COMP_WIDTH-1:0]     gust_y,
    output logic [wvta_pkg::COUNT_W-1:0]     sample_count,
    output logic [TIME_WIDTH-1:0]            interval_ms,
    output logic                             has_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wvta_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wvta_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wvta_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import wvta_pkg::*;

    localparam int CW    = COMP_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int STEPS = (TW > CW) ? TW : CW;
    localparam int CNT_W = $clog2(STEPS);

    // sequencer
    wvta_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    wvta_ctl_t          ctl;
    logic               accept, commit, out_free;

    // accepted transaction
    logic                 kind_reg;
    logic signed [CW-1:0] sx_reg, sy_reg;
    logic [TW-1:0]        time_reg;
    logic [TW-1:0]        w1_reg, w2_reg;
    logic [TW:0]          total_reg;
    logic                 long_reg;
    logic [TW-1:0]        w1_load, w2_load;
    logic [TW:0]          total_load;

    // averaging state
    logic [TW-1:0]        start_reg, last_reg, start_next, last_next;
    logic signed [CW-1:0] mean_x_reg, mean_y_reg, peak_x_reg, peak_y_reg;
    logic signed [CW-1:0] mean_x_next, mean_y_next, peak_x_next, peak_y_next;
    logic [2*CW-1:0]      peak_mag_reg, peak_mag_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 valid_reg, valid_next;

    // result register
    logic                 out_valid_reg;
    logic signed [CW-1:0] avg_x_reg, avg_y_reg, gust_x_reg, gust_y_reg;
    logic [COUNT_W-1:0]   count_out_reg;
    logic [TW-1:0]        interval_reg;
    logic                 has_value_reg;

    logic [MIN_DUR_W-1:0] min_duration;
    logic signed [CW-1:0] quot_x, quot_y;
    logic [2*CW-1:0]      mag;

    wvta_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_duration (min_duration)
    );

    wvta_wavg #(.CW(CW), .TW(TW)) u_wavg_x (
        .clk    (clk),
        .ctl    (ctl),
        .a      (mean_x_reg),
        .b      (sx_reg),
        .w1_bit (w1_reg[TW-1]),
        .w2_bit (w2_reg[TW-1]),
        .total  (total_reg),
        .quot   (quot_x)
    );

    wvta_wavg #(.CW(CW), .TW(TW)) u_wavg_y (
        .clk    (clk),
        .ctl    (ctl),
        .a      (mean_y_reg),
        .b      (sy_reg),
        .w1_bit (w1_reg[TW-1]),
        .w2_bit (w2_reg[TW-1]),
        .total  (total_reg),
        .quot   (quot_y)
    );

    wvta_magsq #(.CW(CW)) u_magsq (
        .clk (clk),
        .ctl (ctl),
        .sx  (sx_reg),
        .sy  (sy_reg),
        .mag (mag)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctl.clear = in_valid;
                if (in_valid)
                begin
                    cnt_next   = CNT_W'(TW - 1);
                    state_next = kind ? ST_COMMIT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DIV_LOAD:
            begin
                ctl.div_load = 1'b1;
                cnt_next     = CNT_W'(CW - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // weights and their sum are fixed at acceptance
    always_comb
    begin
        w1_load    = last_reg - start_reg;
        w2_load    = time_ms - last_reg;
        total_load = {1'b0, w1_load} + {1'b0, w2_load};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            sx_reg    <= sample_x;
            sy_reg    <= sample_y;
            time_reg  <= time_ms;
            w1_reg    <= w1_load;
            w2_reg    <= w2_load;
            total_reg <= total_load;
            long_reg  <= (total_load > (TW + 1)'(min_duration));
        end
        else if (ctl.mul)
        begin
            w1_reg <= {w1_reg[TW-2:0], 1'b0};
            w2_reg <= {w2_reg[TW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        start_next    = start_reg;
        last_next     = last_reg;
        mean_x_next   = mean_x_reg;
        mean_y_next   = mean_y_reg;
        peak_x_next   = peak_x_reg;
        peak_y_next   = peak_y_reg;
        peak_mag_next = peak_mag_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        if (kind_reg)
        begin
            mean_x_next   = '0;
            mean_y_next   = '0;
            peak_x_next   = '0;
            peak_y_next   = '0;
            peak_mag_next = '0;
            count_next    = '0;
            valid_next    = 1'b0;
            start_next    = time_reg;
            last_next     = time_reg;
        end
        else
        begin
            last_next = time_reg;
            if (!valid_reg)
            begin
                // first sample of the interval loads mean and gust, uncounted
                mean_x_next   = sx_reg;
                mean_y_next   = sy_reg;
                peak_x_next   = sx_reg;
                peak_y_next   = sy_reg;
                peak_mag_next = mag;
                valid_next    = 1'b1;
            end
            else
            begin
                mean_x_next = long_reg ? quot_x : sx_reg;
                mean_y_next = long_reg ? quot_y : sy_reg;
                if (mag > peak_mag_reg)
                begin
                    peak_x_next   = sx_reg;
                    peak_y_next   = sy_reg;
                    peak_mag_next = mag;
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            last_reg     <= '0;
            mean_x_reg   <= '0;
            mean_y_reg   <= '0;
            peak_x_reg   <= '0;
            peak_y_reg   <= '0;
            peak_mag_reg <= '0;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
        end
        else if (commit)
        begin
            start_reg    <= start_next;
            last_reg     <= last_next;
            mean_x_reg   <= mean_x_next;
            mean_y_reg   <= mean_y_next;
            peak_x_reg   <= peak_x_next;
            peak_y_reg   <= peak_y_next;
            peak_mag_reg <= peak_mag_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            avg_x_reg     <= mean_x_next;
            avg_y_reg     <= mean_y_next;
            gust_x_reg    <= peak_x_next;
            gust_y_reg    <= peak_y_next;
            count_out_reg <= count_next;
            interval_reg  <= last_next - start_next;
            has_value_reg <= valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign avg_x        = avg_x_reg;
    assign avg_y        = avg_y_reg;
    assign gust_x       = gust_x_reg;
    assign gust_y       = gust_y_reg;
    assign sample_count = count_out_reg;
    assign interval_ms  = interval_reg;
    assign has_value    = has_value_reg;

    `WVTA_ASSERT_NEXT(a_restart_commits, clk, rst_n, accept && kind,
        state_reg == ST_COMMIT, "restart did not go straight to commit")

    `WVTA_ASSERT_NEXT(a_sample_multiplies, clk, rst_n, accept && !kind,
        state_reg == ST_MUL, "sample did not enter the serial multiply")

    `WVTA_ASSERT_NEXT(a_restart_result, clk, rst_n, commit && kind_reg,
        out_valid && !has_value && sample_count == '0 && interval_ms == '0,
        "restart result not cleared")

    `WVTA_ASSERT_SAME(a_empty_state, clk, rst_n, !valid_reg,
        count_reg == '0 && peak_mag_reg == '0, "count or gust held without a value")

endmodule

FILE: bench/tb_wind_vector_time_average_core.sv
// Self-checking testbench for the time-weighted wind vector average core
module tb_wind_vector_time_average_core;
    import wvta_pkg::*;

    localparam int TIME_W = 32;
    localparam int COMP_W = 16;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [APB_ADDR_W-1:0] MIN_DUR_ADDR = {REG_MIN_DURATION, 2'b00};

    typedef struct packed {
        logic                     kind;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic [TIME_W-1:0]        t;
    } wind_reading_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] avg_x;
        logic signed [COMP_W-1:0] avg_y;
        logic signed [COMP_W-1:0] gust_x;
        logic signed [COMP_W-1:0] gust_y;
        logic [COUNT_W-1:0]       count;
        logic [TIME_W-1:0]        interval;
        logic                     has_value;
    } wind_summary_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    kind = KIND_SAMPLE;
    logic signed [COMP_W-1:0] sample_x = '0;
    logic signed [COMP_W-1:0] sample_y = '0;
    logic [TIME_W-1:0]       time_ms = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [COMP_W-1:0] avg_x;
    logic signed [COMP_W-1:0] avg_y;
    logic signed [COMP_W-1:0] gust_x;
    logic signed [COMP_W-1:0] gust_y;
    logic [COUNT_W-1:0]      sample_count;
    logic [TIME_W-1:0]       interval_ms;
    logic                    has_value;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    wind_vector_time_average_core dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state, mirrors the averaging registers of the core
    logic [TIME_W-1:0]        avg_start;
    logic [TIME_W-1:0]        avg_last;
    logic signed [COMP_W-1:0] mean_x;
    logic signed [COMP_W-1:0] mean_y;
    logic signed [COMP_W-1:0] peak_x;
    logic signed [COMP_W-1:0] peak_y;
    longint                   peak_mag;
    logic [COUNT_W-1:0]       avg_count;
    logic                     avg_has_value;
    logic [MIN_DUR_W-1:0]     min_duration = MIN_DUR_RESET;

    wind_reading_t pending_readings[$];
    wind_summary_t expected_summaries[$];
    wind_reading_t reading_on_bus;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int restarts_sent = 0;
    int summaries_checked = 0;
    int duration_writes = 0;

    function automatic longint blend(longint old_v, longint w_old, longint new_v,
                                     longint w_new, longint total);
        longint num;
        num = old_v * w_old + new_v * w_new;
        // signed division truncates toward zero
        return num / total;
    endfunction

    task automatic update_average(input wind_reading_t rd);
        wind_summary_t    s;
        logic [TIME_W-1:0] d_old;
        logic [TIME_W-1:0] d_new;
        longint           t_old;
        longint           t_new;
        longint           total;
        longint           mag;
        if (rd.kind == KIND_RESTART)
        begin
            mean_x = '0;
            mean_y = '0;
            peak_x = '0;
            peak_y = '0;
            peak_mag = 0;
            avg_count = '0;
            avg_has_value = 1'b0;
            avg_start = rd.t;
            avg_last = rd.t;
            restarts_sent++;
        end
        else
        begin
            mag = longint'(rd.x) * longint'(rd.x) + longint'(rd.y) * longint'(rd.y);
            if (!avg_has_value)
            begin
                mean_x = rd.x;
                mean_y = rd.y;
                peak_x = rd.x;
                peak_y = rd.y;
                peak_mag = mag;
                avg_has_value = 1'b1;
            end
            else
            begin
                d_old = avg_last - avg_start;
                d_new = rd.t - avg_last;
                t_old = d_old;
                t_new = d_new;
                total = t_old + t_new;
                if (total > longint'(min_duration))
                begin
                    mean_x = COMP_W'(blend(mean_x, t_old, rd.x, t_new, total));
                    mean_y = COMP_W'(blend(mean_y, t_old, rd.y, t_new, total));
                end
                else
                begin
                    mean_x = rd.x;
                    mean_y = rd.y;
                end
                // only a strictly stronger gust replaces the held one
                if (mag > peak_mag)
                begin
                    peak_x = rd.x;
                    peak_y = rd.y;
                    peak_mag = mag;
                end
                if (avg_count != COUNT_MAX)
                    avg_count++;
            end
            avg_last = rd.t;
            samples_sent++;
        end
        s.avg_x = mean_x;
        s.avg_y = mean_y;
        s.gust_x = peak_x;
        s.gust_y = peak_y;
        s.count = avg_count;
        s.interval = avg_last - avg_start;
        s.has_value = avg_has_value;
        expected_summaries.insert(expected_summaries.size(), s);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // Input driver: present the next queued reading once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                update_average(reading_on_bus);
            if (!in_valid || !in_stall)
            begin
                if (pending_readings.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    reading_on_bus = pending_readings.pop_front();
                    in_valid <= 1'b1;
                    kind     <= reading_on_bus.kind;
                    sample_x <= reading_on_bus.x;
                    sample_y <= reading_on_bus.y;
                    time_ms  <= reading_on_bus.t;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each transaction with the oldest expected summary
    always @(posedge clk)
    begin
        wind_summary_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_summaries.size() == 0)
                    note_mismatch("result arrived with nothing expected");
                else
                begin
                    want = expected_summaries.pop_front();
                    check_field("avg_x", 32'(want.avg_x), 32'(avg_x));
                    check_field("avg_y", 32'(want.avg_y), 32'(avg_y));
                    check_field("gust_x", 32'(want.gust_x), 32'(gust_x));
                    check_field("gust_y", 32'(want.gust_y), 32'(gust_y));
                    check_field("sample_count", 32'(want.count), 32'(sample_count));
                    check_field("interval_ms", want.interval, interval_ms);
                    check_field("has_value", 32'(want.has_value), 32'(has_value));
                    summaries_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic queue_reading(input logic k, input logic [COMP_W-1:0] x,
                                 input logic [COMP_W-1:0] y, input logic [TIME_W-1:0] t);
        wind_reading_t rd;
        rd.kind = k;
        rd.x = x;
        rd.y = y;
        rd.t = t;
        pending_readings.insert(pending_readings.size(), rd);
    endtask

    function automatic logic [COMP_W-1:0] rand_component();
        case ($urandom_range(3))
            0: return COMP_W'($urandom);
            1: return COMP_W'($urandom_range(0, 2047)) - COMP_W'(1024);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return COMP_W'($urandom_range(0, 255)) - COMP_W'(128);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_step();
        case ($urandom_range(5))
            0: return $urandom_range(0, 150);
            1: return $urandom_range(0, 3000);
            // land around the short interval threshold
            2: return TIME_W'(min_duration) + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
            3: return $urandom_range(0, 200000);
            4: return $urandom;
            default: return $urandom_range(1, 2000000);
        endcase
    endfunction

    task automatic queue_random(input int n);
        int               made;
        int               burst;
        int               k;
        logic [TIME_W-1:0] t;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: arbitrary kind and timestamp
                queue_reading(1'($urandom), rand_component(), rand_component(), $urandom);
                made++;
            end
            else
            begin
                t = $urandom_range(1) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 1000));
                queue_reading(KIND_RESTART, rand_component(), rand_component(), t);
                made++;
                burst = $urandom_range(1, 10);
                for (k = 0; k < burst; k++)
                begin
                    t += rand_step();
                    queue_reading(KIND_SAMPLE, rand_component(), rand_component(), t);
                    made++;
                end
            end
        end
    endtask

    task automatic queue_directed();
        // samples before any restart, interval start still at zero
        queue_reading(KIND_SAMPLE, 16'sd100, -16'sd50, 32'd1000);
        queue_reading(KIND_SAMPLE, 16'h7FFF, 16'h8000, 32'd5000);
        // restart close to the time wrap, extremes, short interval
        queue_reading(KIND_RESTART, 16'h7FFF, 16'h7FFF, 32'hFFFF_FF00);
        queue_reading(KIND_SAMPLE, 16'h8000, 16'h8000, 32'hFFFF_FF10);
        queue_reading(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 32'hFFFF_FF20);
        queue_reading(KIND_SAMPLE, 16'sd0, 16'sd0, 32'h0000_0100);
        // back to back restarts, then gusts of equal strength
        queue_reading(KIND_RESTART, 16'sd0, 16'sd0, 32'd12345);
        queue_reading(KIND_RESTART, 16'h8000, 16'h7FFF, 32'd12345);
        queue_reading(KIND_SAMPLE, 16'sd3, 16'sd4, 32'd12400);
        queue_reading(KIND_SAMPLE, -16'sd4, 16'sd3, 32'd12500);
        queue_reading(KIND_SAMPLE, 16'sd0, -16'sd5, 32'd12600);
        queue_reading(KIND_SAMPLE, -16'sd1, -16'sd1, 32'd12600);
        // very long steps, one running backwards modulo the wrap
        queue_reading(KIND_SAMPLE, 16'sd6, 16'sd0, 32'h8000_0000);
        queue_reading(KIND_SAMPLE, -16'sd7, -16'sd7, 32'h7FFF_FFFF);
        queue_reading(KIND_RESTART, 16'sd1, 16'sd1, 32'd0);
        queue_reading(KIND_SAMPLE, 16'sd0, 16'sd0, 32'd0);
        queue_reading(KIND_SAMPLE, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        queue_reading(KIND_SAMPLE, 16'sd1, 16'sd1, 32'd50);
        // weight total exactly at the threshold, then just above it
        queue_reading(KIND_RESTART, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
        queue_reading(KIND_SAMPLE, 16'sd1, -16'sd1, 32'hFFFF_FFFF);
        queue_reading(KIND_SAMPLE, -16'sd1, 16'sd1, 32'd99);
        queue_reading(KIND_SAMPLE, 16'sd2, 16'sd2, 32'd100);
    endtask

    task automatic drain();
        while (pending_readings.size() != 0 || in_valid || expected_summaries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_duration(input logic [MIN_DUR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MIN_DUR_ADDR;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        min_duration = value;
        duration_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_min_duration();
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= MIN_DUR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("min_duration_ms", 32'(min_duration), 32'(prdata[MIN_DUR_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        avg_start = '0;
        avg_last = '0;
        mean_x = '0;
        mean_y = '0;
        peak_x = '0;
        peak_y = '0;
        peak_mag = 0;
        avg_count = '0;
        avg_has_value = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold, no idling
        check_min_duration();
        queue_directed();
        queue_random(90);
        drain();

        write_min_duration('0);
        check_min_duration();
        sender_idle_pct = 49;
        receiver_stall_pct = 0;
        queue_random(100);
        drain();

        write_min_duration('1);
        check_min_duration();
        sender_idle_pct = 0;
        receiver_stall_pct = 49;
        queue_random(100);
        drain();

        write_min_duration(MIN_DUR_W'($urandom_range(1, 65534)));
        check_min_duration();
        sender_idle_pct = 15;
        receiver_stall_pct = 15;
        queue_random(100);
        drain();

        // hold off to catch any stray result
        repeat (80) @(posedge clk);
        $display("Sent %0d wind samples and %0d restarts through four idling phases,",
                 samples_sent, restarts_sent);
        $display("%0d threshold writes, %0d results checked, %0d mismatches",
                 duration_writes, summaries_checked, mismatches);
        if (mismatches == 0 && expected_summaries.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/wvta_pkg.sv
hw/rtl/wvta_cfg.sv
hw/rtl/wvta_magsq.sv
hw/rtl/wvta_wavg.sv
hw/rtl/wind_vector_time_average_core.sv
bench/tb_wind_vector_time_average_core.sv
